/* hw/rtl/cfpd_pkg.sv */
// Shared constants, face tables and helpers for the cube face pixel direction block.
// No dependencies.
package cfpd_pkg;

  localparam int MAX_RES  = 4096;
  localparam int RES_W    = 13;
  localparam int PIX_W    = 24;
  localparam int COORD_W  = 12;   // column/row bits below MAX_RES
  localparam int D_W      = 15;   // signed scaled component
  localparam int MAG_W    = 13;
  localparam int SQ_W     = 2 * MAG_W - 1;  // 25 bits, mag <= 4096
  localparam int SUM_W    = SQ_W + 1;
  localparam int QUO_BITS = 33;   // floor(mag^2 * 2^32 / s) <= 2^32
  localparam int ROOT_BITS = 17;
  localparam int NORM_LAT = QUO_BITS + ROOT_BITS + 1;
  localparam int OUT_W    = 16;

  // config register byte address
  localparam logic [2:0] ADDR_RESOLUTION = 3'd0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_RES = 2'd1,
    ST_BAD_FACE = 2'd2,
    ST_BAD_PIX  = 2'd3
  } status_t;

  localparam logic [2:0] FACE_MAX = 3'd5;

  // Face corner and half edge vectors, one entry per axis.
  localparam logic signed [1:0] FACE_ORG [6][3] = '{
    '{-2'sd1, -2'sd1, -2'sd1}, '{-2'sd1,  2'sd1,  2'sd1}, '{ 2'sd1, -2'sd1,  2'sd1},
    '{-2'sd1, -2'sd1, -2'sd1}, '{ 2'sd1, -2'sd1, -2'sd1}, '{-2'sd1, -2'sd1,  2'sd1}};
  localparam logic signed [1:0] FACE_EU [6][3] = '{
    '{ 2'sd1,  2'sd0,  2'sd0}, '{ 2'sd1,  2'sd0,  2'sd0}, '{ 2'sd0,  2'sd1,  2'sd0},
    '{ 2'sd0,  2'sd1,  2'sd0}, '{-2'sd1,  2'sd0,  2'sd0}, '{ 2'sd1,  2'sd0,  2'sd0}};
  localparam logic signed [1:0] FACE_EV [6][3] = '{
    '{ 2'sd0,  2'sd0,  2'sd1}, '{ 2'sd0,  2'sd0, -2'sd1}, '{ 2'sd0,  2'sd0, -2'sd1},
    '{ 2'sd0,  2'sd0,  2'sd1}, '{ 2'sd0,  2'sd1,  2'sd0}, '{ 2'sd0,  2'sd1,  2'sd0}};

  // coef in {-1,0,1} times an unsigned 13-bit value
  function automatic logic signed [D_W-1:0] axis_term(logic signed [1:0] coef,
                                                      logic [RES_W-1:0] val);
    logic signed [D_W-1:0] v;
    v = $signed({2'b00, val});
    if (coef == 2'sd1) return v;
    else if (coef == -2'sd1) return -v;
    else return '0;
  endfunction

endpackage

/* hw/rtl/cfpd_norm.sv */
// One component of the normalizer: pipelined restoring divide then integer root.
// Depends on cfpd_pkg.
module cfpd_norm import cfpd_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [SQ_W-1:0]         mag2,
  input  logic [SUM_W-1:0]        s,
  input  logic                    neg,
  output logic signed [OUT_W-1:0] dir
);

  // divide stages: quotient of mag2 * 2^32 by s, one bit per stage
  logic [SUM_W-1:0]    rem  [QUO_BITS];
  logic [QUO_BITS-1:0] quo  [QUO_BITS];
  logic [SUM_W-1:0]    dsr  [QUO_BITS];
  logic                dneg [QUO_BITS];

  logic              ge0;
  logic [SUM_W-1:0]  m2w;
  assign m2w = {1'b0, mag2};
  assign ge0 = m2w >= s;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= ge0 ? m2w - s : m2w;
      quo[0]  <= {{(QUO_BITS-1){1'b0}}, ge0};
      dsr[0]  <= s;
      dneg[0] <= neg;
    end
  end

  for (genvar k = 1; k < QUO_BITS; k++) begin : g_div
    logic [SUM_W:0] t;
    logic           ge;
    assign t  = {rem[k-1], 1'b0};
    assign ge = t >= {1'b0, dsr[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? SUM_W'(t - {1'b0, dsr[k-1]}) : t[SUM_W-1:0];
        quo[k]  <= {quo[k-1][QUO_BITS-2:0], ge};
        dsr[k]  <= dsr[k-1];
        dneg[k] <= dneg[k-1];
      end
    end
  end

  // root stages: rm holds Q - m^2
  localparam int RM_W = QUO_BITS + 1;
  logic [RM_W-1:0]      rm   [ROOT_BITS];
  logic [ROOT_BITS-1:0] root [ROOT_BITS];
  logic                 rneg [ROOT_BITS];

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
    localparam int B = ROOT_BITS - 1 - j;
    logic [RM_W-1:0]      rm_in;
    logic [ROOT_BITS-1:0] m_in;
    logic                 n_in;
    logic [RM_W-1:0]      trial;
    logic                 ge;
    if (j == 0) begin : g_first
      assign rm_in = {1'b0, quo[QUO_BITS-1]};
      assign m_in  = '0;
      assign n_in  = dneg[QUO_BITS-1];
    end else begin : g_next
      assign rm_in = rm[j-1];
      assign m_in  = root[j-1];
      assign n_in  = rneg[j-1];
    end
    assign trial = ({{(RM_W-ROOT_BITS){1'b0}}, m_in} << (B + 1))
                 + ({{(RM_W-1){1'b0}}, 1'b1} << (2 * B));
    assign ge = rm_in >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rm[j]   <= ge ? rm_in - trial : rm_in;
        root[j] <= ge ? (m_in | (ROOT_BITS'(1) << B)) : m_in;
        rneg[j] <= n_in;
      end
    end
  end

  // round half up on the doubled root, then sign and saturate
  logic [ROOT_BITS:0]   rsum;
  logic [ROOT_BITS-1:0] q;
  assign rsum = {1'b0, root[ROOT_BITS-1]} + (ROOT_BITS+1)'(1);
  assign q    = rsum[ROOT_BITS:1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (rneg[ROOT_BITS-1]) begin
        dir <= (q > ROOT_BITS'(32768)) ? -OUT_W'(32768) : -OUT_W'(q);
      end else begin
        dir <= (q > ROOT_BITS'(32767)) ? OUT_W'(32767) : OUT_W'(q);
      end
    end
  end

endmodule

/* hw/rtl/cube_face_pixel_direction.sv */
// Top level of the cube face pixel direction block: config register, pixel split,
// face vector, squares, and three normalizer lanes. Depends on cfpd_pkg, cfpd_norm.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  in       | in_valid / in_stall   | face[2:0], pixel_number[23:0]
//  out      | out_valid / out_stall | dir_x, dir_y, dir_z [15:0], status[1:0]
//  config   | APB write/read        | resolution at byte address 0
//
// One item per clock unless the output stalls: 2 entry stages, 12 column/row
// divide stages (one quotient bit each), 3 vector/square/sum stages, 51 normalizer
// stages (33 divide bits, 17 root bits, rounding) and the output register.
// rst clears the valid bits and sets resolution to 256.
// A stalled output holds the whole pipe; in_stall is raised in the same cycle.
module cube_face_pixel_direction import cfpd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              face,
  input  logic [PIX_W-1:0]        pixel_number,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] dir_x,
  output logic signed [OUT_W-1:0] dir_y,
  output logic signed [OUT_W-1:0] dir_z,
  output logic [1:0]              status
);

  localparam int NDIV = COORD_W;

  // config register
  logic [RES_W-1:0] resolution;
  assign pready = 1'b1;
  assign prdata = {{(32-RES_W){1'b0}}, resolution};
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= RES_W'(256);
    end else if (psel && penable && pwrite && paddr == ADDR_RESOLUTION) begin
      resolution <= pwdata[RES_W-1:0];
    end
  end

  // whole pipe moves unless the output holds an item that is stalled
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // entry stage: clamp resolution
  logic             a_v;
  logic [2:0]       a_face;
  logic [PIX_W-1:0] a_pix;
  logic [RES_W-1:0] a_r;
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_face <= face;
      a_pix  <= pixel_number;
      a_r    <= (resolution > RES_W'(MAX_RES)) ? RES_W'(MAX_RES) : resolution;
    end
  end

  // error check; divide starts from the top 12 pixel bits (below r when in range)
  logic [2*RES_W-1:0] a_sq;
  status_t            a_st;
  assign a_sq = a_r * a_r;
  always_comb begin
    priority if (a_r == '0)                       a_st = ST_ZERO_RES;
    else if (a_face > FACE_MAX)                   a_st = ST_BAD_FACE;
    else if ({2'b00, a_pix} >= a_sq)              a_st = ST_BAD_PIX;
    else                                          a_st = ST_OK;
  end

  logic             b_v;
  status_t          b_st;
  logic [2:0]       b_face;
  logic [RES_W-1:0] b_r;
  logic [RES_W-1:0] b_rem;
  logic [NDIV-1:0]  b_low;
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (adv) b_v <= a_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_st   <= a_st;
      b_face <= (a_face > FACE_MAX) ? 3'd0 : a_face;
      b_r    <= a_r;
      b_rem  <= {1'b0, a_pix[PIX_W-1:NDIV]};
      b_low  <= a_pix[NDIV-1:0];
    end
  end

  // column/row divide, one quotient bit per stage
  logic             dv_v    [NDIV];
  status_t          dv_st   [NDIV];
  logic [2:0]       dv_face [NDIV];
  logic [RES_W-1:0] dv_r    [NDIV];
  logic [RES_W-1:0] dv_rem  [NDIV];
  logic [NDIV-1:0]  dv_low  [NDIV];
  logic [NDIV-1:0]  dv_quo  [NDIV];

  for (genvar j = 0; j < NDIV; j++) begin : g_pdiv
    logic             v_in;
    status_t          st_in;
    logic [2:0]       f_in;
    logic [RES_W-1:0] r_in;
    logic [RES_W-1:0] rem_in;
    logic [NDIV-1:0]  low_in;
    logic [NDIV-1:0]  quo_in;
    logic [RES_W:0]   t;
    logic             ge;
    if (j == 0) begin : g_first
      assign v_in = b_v;   assign st_in = b_st; assign f_in = b_face;
      assign r_in = b_r;   assign rem_in = b_rem; assign low_in = b_low;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in = dv_v[j-1];   assign st_in = dv_st[j-1]; assign f_in = dv_face[j-1];
      assign r_in = dv_r[j-1];   assign rem_in = dv_rem[j-1];
      assign low_in = dv_low[j-1]; assign quo_in = dv_quo[j-1];
    end
    assign t  = {rem_in, low_in[NDIV-1]};
    assign ge = t >= {1'b0, r_in};
    always_ff @(posedge clk) begin
      if (rst) dv_v[j] <= 1'b0;
      else if (adv) dv_v[j] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_st[j]   <= st_in;
        dv_face[j] <= f_in;
        dv_r[j]    <= r_in;
        dv_rem[j]  <= ge ? RES_W'(t - {1'b0, r_in}) : t[RES_W-1:0];
        dv_low[j]  <= {low_in[NDIV-2:0], 1'b0};
        dv_quo[j]  <= {quo_in[NDIV-2:0], ge};
      end
    end
  end

  // scaled pixel-center vector: o*r + a*(2x+1) + b*(2y+1)
  logic [COORD_W-1:0] px, py;
  logic [RES_W-1:0]   ux, vy;
  logic [2:0]         pf;
  logic [RES_W-1:0]   pr;
  assign px = dv_rem[NDIV-1][COORD_W-1:0];
  assign py = dv_quo[NDIV-1];
  assign ux = {px, 1'b1};
  assign vy = {py, 1'b1};
  assign pf = dv_face[NDIV-1];
  assign pr = dv_r[NDIV-1];

  logic                  c_v;
  status_t               c_st;
  logic signed [D_W-1:0] c_d [3];
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (adv) c_v <= dv_v[NDIV-1];
  end
  for (genvar c = 0; c < 3; c++) begin : g_vec
    always_ff @(posedge clk) begin
      if (adv) begin
        c_d[c] <= axis_term(FACE_ORG[pf][c], pr)
                + axis_term(FACE_EU[pf][c], ux)
                + axis_term(FACE_EV[pf][c], vy);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) c_st <= dv_st[NDIV-1];
  end

  // magnitudes squared
  logic            e_v;
  status_t         e_st;
  logic [SQ_W-1:0] e_sq  [3];
  logic            e_neg [3];
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (adv) e_v <= c_v;
  end
  for (genvar c = 0; c < 3; c++) begin : g_sq
    logic [D_W-1:0]   absd;
    logic [MAG_W-1:0] mag;
    assign absd = c_d[c][D_W-1] ? D_W'(-c_d[c]) : D_W'(c_d[c]);
    assign mag  = absd[MAG_W-1:0];
    always_ff @(posedge clk) begin
      if (adv) begin
        e_sq[c]  <= SQ_W'(mag) * SQ_W'(mag);
        e_neg[c] <= c_d[c][D_W-1];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) e_st <= c_st;
  end

  // length squared
  logic             f_v;
  status_t          f_st;
  logic [SUM_W-1:0] f_s;
  logic [SQ_W-1:0]  f_sq  [3];
  logic             f_neg [3];
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (adv) f_v <= e_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f_st  <= e_st;
      f_s   <= {1'b0, e_sq[0]} + {1'b0, e_sq[1]} + {1'b0, e_sq[2]};
      f_sq  <= e_sq;
      f_neg <= e_neg;
    end
  end

  // three normalizer lanes
  logic signed [OUT_W-1:0] n_dir [3];
  for (genvar c = 0; c < 3; c++) begin : g_lane
    cfpd_norm u_norm (
      .clk  (clk),
      .en   (adv),
      .mag2 (f_sq[c]),
      .s    (f_s),
      .neg  (f_neg[c]),
      .dir  (n_dir[c])
    );
  end

  // valid and status ride alongside the lanes
  logic    n_v  [NORM_LAT];
  status_t n_st [NORM_LAT];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NORM_LAT; i++) n_v[i] <= 1'b0;
    end else if (adv) begin
      n_v[0] <= f_v;
      for (int i = 1; i < NORM_LAT; i++) n_v[i] <= n_v[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      n_st[0] <= f_st;
      for (int i = 1; i < NORM_LAT; i++) n_st[i] <= n_st[i-1];
    end
  end

  // output register; errors give a zero direction
  logic ok;
  assign ok = n_st[NORM_LAT-1] == ST_OK;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= n_v[NORM_LAT-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dir_x  <= ok ? n_dir[0] : '0;
      dir_y  <= ok ? n_dir[1] : '0;
      dir_z  <= ok ? n_dir[2] : '0;
      status <= n_st[NORM_LAT-1];
    end
  end

endmodule

/* tb/tb_cube_face_pixel_direction.sv */
// Testbench for cube_face_pixel_direction: a self-checking run with its own pixel direction predictor.
// Depends on cfpd_pkg and the cube_face_pixel_direction RTL.
module tb_cube_face_pixel_direction;
  import cfpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 69;
  localparam int CYCLE_CAP = 400000;
  localparam logic [2:0] ADDR_UNUSED     = 3'd4;

  typedef struct packed {
    logic [2:0]       face;
    logic [PIX_W-1:0] pix;
  } pix_item_t;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    status_t            st;
  } dir_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] face = '0;
  logic [PIX_W-1:0] pixel_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic [1:0] status;

  cube_face_pixel_direction uut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor's copy of the resolution register.
  logic [12:0] res_shadow = 13'd256;

  pix_item_t   pending_pixels[$];
  dir_result_t expected_dirs[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_sender = 1'b0;
  longint unsigned cycles = 0;

  // Face tables: corner and half edge vectors per axis.
  int corner[6][3] = '{'{-1,-1,-1}, '{-1,1,1}, '{1,-1,1}, '{-1,-1,-1}, '{1,-1,-1},
                       '{-1,-1,1}};
  int edge_u[6][3] = '{'{1,0,0}, '{1,0,0}, '{0,1,0}, '{0,1,0}, '{-1,0,0}, '{1,0,0}};
  int edge_v[6][3] = '{'{0,0,1}, '{0,0,-1}, '{0,0,-1}, '{0,0,1}, '{0,1,0}, '{0,1,0}};

  // Scale one component to Q1.15: round(|d| * 2^15 / sqrt(s)), ties away,
  // via bitwise root search of 4*d^2*2^30/s, then sign and saturate.
  function automatic logic signed [15:0] unit_component(longint d, longint unsigned s);
    longint unsigned mag, lim, m, t, q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    if (s == 0 || mag == 0) return '0;
    lim = 4 * mag * mag;
    if (lim > (64'hFFFF_FFFF_FFFF_FFFF >> 30)) lim = 64'hFFFF_FFFF_FFFF_FFFF;
    else lim = lim << 30;
    m = 0;
    for (int b = 16; b >= 0; b--) begin
      t = m | (64'd1 << b);
      if (t * t * s <= lim) m = t;
    end
    q = (m + 1) >> 1;
    if (d < 0) begin
      if (q > 32768) q = 32768;
      return 16'((17'h10000 - q) & 17'hFFFF);
    end
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  function automatic dir_result_t predict_direction(pix_item_t it, logic [12:0] res_reg);
    dir_result_t r;
    longint unsigned rr, x, y, s;
    longint dv[3];
    r = '{dx: '0, dy: '0, dz: '0, st: ST_OK};
    rr = res_reg;
    if (rr > MAX_RES) rr = MAX_RES;
    if (rr == 0) begin
      r.st = ST_ZERO_RES;
      return r;
    end
    if (it.face > FACE_MAX) begin
      r.st = ST_BAD_FACE;
      return r;
    end
    if (it.pix >= rr * rr) begin
      r.st = ST_BAD_PIX;
      return r;
    end
    x = it.pix % rr;
    y = it.pix / rr;
    s = 0;
    for (int c = 0; c < 3; c++) begin
      dv[c] = corner[it.face][c] * longint'(rr) + edge_u[it.face][c] * longint'(2 * x + 1)
            + edge_v[it.face][c] * longint'(2 * y + 1);
      s += longint'(dv[c] * dv[c]);
    end
    r.dx = unit_component(dv[0], s);
    r.dy = unit_component(dv[1], s);
    r.dz = unit_component(dv[2], s);
    return r;
  endfunction

  // Driver: presents the head of pending_pixels; predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_dirs.push_back(predict_direction('{face: face, pix: pixel_number},
                                                  res_shadow));
        void'(pending_pixels.pop_front());
        items_sent++;
      end
      // Stay on a held item; otherwise pick the next one, maybe idling.
      if (!(in_valid && in_stall)) begin
        if (pending_pixels.size() != 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid     <= 1'b1;
          face         <= pending_pixels[0].face;
          pixel_number <= pending_pixels[0].pix;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest prediction.
  always @(posedge clk) begin
    dir_result_t want;
    cycles++;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_dirs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result x=%0d y=%0d z=%0d st=%0d", $time,
                   dir_x, dir_y, dir_z, status);
        end else begin
          want = expected_dirs.pop_front();
          if (dir_x !== want.dx || dir_y !== want.dy || dir_z !== want.dz ||
              status !== want.st) begin
            mismatches++;
            $display({"%0t: mismatch expected x=%0d y=%0d z=%0d st=%0d, ",
                      "got x=%0d y=%0d z=%0d st=%0d"},
                     $time, want.dx, want.dy, want.dz, want.st, dir_x, dir_y, dir_z, status);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_dirs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // APB write: setup then access phase; pready is always high.
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_RESOLUTION) res_shadow = data[12:0];
  endtask

  // Wait until every queued item is sent and answered, then the pipe drains.
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_valid || expected_dirs.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Random pixel: mostly inside the face, some beyond its edge, sometimes on an unused face number.
  function automatic pix_item_t random_pixel();
    pix_item_t it;
    longint unsigned rr;
    rr = (res_shadow > MAX_RES) ? MAX_RES : res_shadow;
    it.face = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
    case ($urandom_range(9))
      0: it.pix = 24'($urandom);
      1: it.pix = (rr * rr > 0) ? 24'(rr * rr - 1 + $urandom_range(2)) : 24'($urandom);
      default: it.pix = (rr > 0) ? 24'($urandom % (rr * rr)) : 24'($urandom);
    endcase
    return it;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) pending_pixels.push_back(random_pixel());
  endtask

  initial begin
    logic [12:0] res_list[6] = '{13'd1, 13'd4096, 13'd8191, 13'd3, 13'd256, 13'd4097};
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset resolution, every face, corners, centre, errors.
    for (int f = 0; f < 8; f++) begin
      pending_pixels.push_back('{face: 3'(f), pix: 24'd0});
      pending_pixels.push_back('{face: 3'(f), pix: 24'd65535});
    end
    pending_pixels.push_back('{face: 3'd0, pix: 24'd255});
    pending_pixels.push_back('{face: 3'd2, pix: 24'd32896});
    pending_pixels.push_back('{face: 3'd4, pix: 24'd65536});
    pending_pixels.push_back('{face: 3'd1, pix: 24'hFFFFFF});
    pending_pixels.push_back('{face: 3'd7, pix: 24'hFFFFFF});
    wait_drained();

    // Zero resolution and an unmapped address.
    apb_write(ADDR_RESOLUTION, 32'd0);
    apb_write(ADDR_UNUSED, 32'd7);
    pending_pixels.push_back('{face: 3'd0, pix: 24'd0});
    pending_pixels.push_back('{face: 3'd6, pix: 24'd5});
    wait_drained();

    // Random phases across resolutions and idling patterns.
    for (int p = 0; p < 6; p++) begin
      apb_write(ADDR_RESOLUTION, 32'(res_list[p]) | ($urandom & 32'hFFFF_E000));
      send_idle_pct = (p < 2) ? 31 : (p < 4) ? 68 : 0;
      recv_idle_pct = (p < 2) ? 68 : (p < 4) ? 31 : 0;
      run_random(60);
      // Sender holds off until everything in flight has come back.
      while (pending_pixels.size() != 0 || in_valid) @(posedge clk);
      hold_sender = 1'b1;
      while (expected_dirs.size() != 0) @(posedge clk);
      hold_sender = 1'b0;
      run_random(70);
      wait_drained();
    end

    $display("sent %0d items, checked %0d results over 8 resolution settings",
             items_sent, results_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
